### hw/rtl/csub_pkg.sv
// ----------------------------------------------------------------------------
// csub_pkg
// Shared types, sizes and codes of the channel subscription table.
// ----------------------------------------------------------------------------
package csub_pkg;

	// table geometry
	localparam int ROUTES         = 16;
	localparam int SUBS_PER_ROUTE = 8;

	localparam int RT_W   = (ROUTES > 1) ? $clog2(ROUTES) : 1;
	localparam int CNT_W  = $clog2(SUBS_PER_ROUTE + 1);
	localparam int DEPTH  = ROUTES * SUBS_PER_ROUTE;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W   = 16;
	localparam int ID_W   = 32;

	typedef enum logic {
		OP_SUBSCRIBE   = 1'b0,
		OP_UNSUBSCRIBE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_HANDLE = 2'd1,
		ST_FULL       = 2'd2,
		ST_NOT_FOUND  = 2'd3
	} status_t;

	// request and response payloads
	typedef struct packed {
		opcode_t           opcode;
		logic [CH_W-1:0]   channel;
		logic [ID_W-1:0]   subscriber_id;
		logic              handle_ok;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  count_after;
	} rsp_t;

	// which count goes into the response
	typedef enum logic [1:0] {
		CS_ZERO,
		CS_CUR,
		CS_INC,
		CS_DEC
	} cnt_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_DECIDE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} fsm_state_t;

	// controller to datapath
	typedef struct packed {
		logic      load_req;
		logic      lookup;
		logic      claim;
		logic      clr_idx;
		logic      inc_idx;
		logic      rd_scan;
		logic      rd_next;
		logic      wr_append;
		logic      wr_shift;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      set_res;
		status_t   res_status;
		cnt_sel_t  res_cnt;
		logic      out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic  unsub;
		logic  handle_ok;
		logic  hit;
		logic  free_avail;
		logic  idx_lt_cnt;
		logic  next_lt_cnt;
		logic  list_full;
		logic  id_match;
		logic  out_busy;
	} dp_status_t;

endpackage

### hw/rtl/channel_subscription_table.sv
// ----------------------------------------------------------------------------
// channel_subscription_table
// Route table of channels with ordered subscriber lists; subscribe and
// unsubscribe requests, one status and count per request.
// ----------------------------------------------------------------------------
// One request is worked at a time. A request refused before the list is
// touched goes from the lookup and the decision straight to the response
// step. Any other request walks the route's subscriber list: an append, a
// removal and an unsubscribe of a missing id always walk the whole list; a
// duplicate subscribe stops at the matching entry. The list memory has a
// registered read, so the duplicate scan reads an entry and then compares
// it, and the shift-delete reads the next entry and then writes it one
// place down. A new request is taken while the previous response still
// sits in the output register; a stalled response holds the next one in
// its last step until the output register frees. The list memory needs no
// clearing after reset.
module channel_subscription_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  csub_pkg::req_t    req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output csub_pkg::rsp_t    rsp_data
);

	csub_pkg::cmd_t        cmd;
	csub_pkg::dp_status_t  sts;

	// sequencer
	csub_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table and list datapath
	csub_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### hw/rtl/csub_ram.sv
// ----------------------------------------------------------------------------
// csub_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csub_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/csub_ctrl.sv
// ----------------------------------------------------------------------------
// csub_ctrl
// Request sequencer: lookup, list scan, append and shift-delete steps.
// ----------------------------------------------------------------------------
module csub_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  csub_pkg::dp_status_t   sts,
	output csub_pkg::cmd_t         cmd
);

	csub_pkg::fsm_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csub_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csub_pkg::S_IDLE: begin
				if (req_valid) state_d = csub_pkg::S_LOOKUP;
			end
			csub_pkg::S_LOOKUP: begin
				state_d = csub_pkg::S_DECIDE;
			end
			csub_pkg::S_DECIDE: begin
				priority if (!sts.unsub && !sts.handle_ok) state_d = csub_pkg::S_DONE;
				else if (!sts.unsub && !sts.hit && !sts.free_avail) state_d = csub_pkg::S_DONE;
				else if (sts.unsub && !sts.hit) state_d = csub_pkg::S_DONE;
				else state_d = csub_pkg::S_SCAN_RD;
			end
			csub_pkg::S_SCAN_RD: begin
				if (sts.idx_lt_cnt) state_d = csub_pkg::S_SCAN_CMP;
				else state_d = csub_pkg::S_DONE;
			end
			csub_pkg::S_SCAN_CMP: begin
				priority if (sts.id_match && sts.unsub) state_d = csub_pkg::S_SHIFT_RD;
				else if (sts.id_match) state_d = csub_pkg::S_DONE;
				else state_d = csub_pkg::S_SCAN_RD;
			end
			csub_pkg::S_SHIFT_RD: begin
				if (sts.next_lt_cnt) state_d = csub_pkg::S_SHIFT_WR;
				else state_d = csub_pkg::S_DONE;
			end
			csub_pkg::S_SHIFT_WR: begin
				state_d = csub_pkg::S_SHIFT_RD;
			end
			csub_pkg::S_DONE: begin
				if (!sts.out_busy) state_d = csub_pkg::S_IDLE;
			end
			default: state_d = csub_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd            = '0;
		cmd.res_status = csub_pkg::ST_OK;
		cmd.res_cnt    = csub_pkg::CS_ZERO;
		req_stall      = (state_q != csub_pkg::S_IDLE);
		unique case (state_q)
			csub_pkg::S_IDLE: begin
				cmd.load_req = req_valid;
			end
			csub_pkg::S_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			csub_pkg::S_DECIDE: begin
				priority if (!sts.unsub && !sts.handle_ok) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = csub_pkg::ST_BAD_HANDLE;
				end else if (!sts.unsub && !sts.hit && !sts.free_avail) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = csub_pkg::ST_FULL;
				end else if (sts.unsub && !sts.hit) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = csub_pkg::ST_NOT_FOUND;
				end else begin
					cmd.clr_idx = 1'b1;
					cmd.claim   = !sts.unsub && !sts.hit;
				end
			end
			csub_pkg::S_SCAN_RD: begin
				priority if (sts.idx_lt_cnt) begin
					cmd.rd_scan = 1'b1;
				end else if (sts.unsub) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = csub_pkg::ST_NOT_FOUND;
					cmd.res_cnt    = csub_pkg::CS_CUR;
				end else if (sts.list_full) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = csub_pkg::ST_FULL;
					cmd.res_cnt    = csub_pkg::CS_CUR;
				end else begin
					cmd.wr_append  = 1'b1;
					cmd.cnt_inc    = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = csub_pkg::ST_OK;
					cmd.res_cnt    = csub_pkg::CS_INC;
				end
			end
			csub_pkg::S_SCAN_CMP: begin
				// duplicate subscribe counts as success
				if (sts.id_match && !sts.unsub) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = csub_pkg::ST_OK;
					cmd.res_cnt    = csub_pkg::CS_CUR;
				end else if (!sts.id_match) begin
					cmd.inc_idx = 1'b1;
				end
			end
			csub_pkg::S_SHIFT_RD: begin
				if (sts.next_lt_cnt) begin
					cmd.rd_next = 1'b1;
				end else begin
					cmd.cnt_dec    = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = csub_pkg::ST_OK;
					cmd.res_cnt    = csub_pkg::CS_DEC;
				end
			end
			csub_pkg::S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.inc_idx  = 1'b1;
			end
			csub_pkg::S_DONE: begin
				cmd.out_load = !sts.out_busy;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

### hw/rtl/csub_dp.sv
// ----------------------------------------------------------------------------
// csub_dp
// Route table registers, subscriber list memory, scan index and result
// registers.
// ----------------------------------------------------------------------------
module csub_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  csub_pkg::req_t         req_data,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output csub_pkg::rsp_t         rsp_data,
	input  csub_pkg::cmd_t         cmd,
	output csub_pkg::dp_status_t   sts
);

	localparam int RT_W   = csub_pkg::RT_W;
	localparam int CNT_W  = csub_pkg::CNT_W;
	localparam int ADDR_W = csub_pkg::ADDR_W;
	localparam logic [ADDR_W-1:0] SUBS_A = ADDR_W'(csub_pkg::SUBS_PER_ROUTE);
	localparam logic [CNT_W-1:0]  SUBS_C = CNT_W'(csub_pkg::SUBS_PER_ROUTE);

	csub_pkg::req_t                req_q;
	logic                          route_valid_q [csub_pkg::ROUTES];
	logic [csub_pkg::CH_W-1:0]     route_channel_q [csub_pkg::ROUTES];
	logic [CNT_W-1:0]              route_count_q [csub_pkg::ROUTES];
	logic [RT_W-1:0]               route_q;
	logic                          hit_q;
	logic                          free_q;
	logic [CNT_W-1:0]              idx_q;
	csub_pkg::status_t             res_status_q;
	logic [CNT_W-1:0]              res_cnt_q;
	logic                          out_valid_q;
	csub_pkg::rsp_t                out_q;

	logic                          hit_c;
	logic                          free_c;
	logic [RT_W-1:0]               hit_idx;
	logic [RT_W-1:0]               free_idx;
	logic [CNT_W-1:0]              n_cur;
	logic [ADDR_W-1:0]             base;
	logic                          ram_we;
	logic [ADDR_W-1:0]             ram_waddr;
	logic                          ram_re;
	logic [ADDR_W-1:0]             ram_raddr;
	logic [csub_pkg::ID_W-1:0]     ram_wdata;
	logic [csub_pkg::ID_W-1:0]     ram_rdata;
	logic [CNT_W:0]                idx_next;

	// request register
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_data;
		end
	end

	// route search: lowest matching valid route and lowest free route
	always_comb begin
		hit_c    = 1'b0;
		free_c   = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int r = csub_pkg::ROUTES - 1; r >= 0; r--) begin
			if (route_valid_q[r] && route_channel_q[r] == req_q.channel) begin
				hit_c   = 1'b1;
				hit_idx = RT_W'(r);
			end
			if (!route_valid_q[r]) begin
				free_c   = 1'b1;
				free_idx = RT_W'(r);
			end
		end
	end

	// lookup result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_q <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.lookup) begin
			route_q <= hit_c ? hit_idx : free_idx;
			hit_q   <= hit_c;
			free_q  <= free_c;
		end
	end

	assign n_cur = route_count_q[route_q];

	// route table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < csub_pkg::ROUTES; r++) begin
				route_valid_q[r]   <= 1'b0;
				route_channel_q[r] <= '0;
				route_count_q[r]   <= '0;
			end
		end else begin
			if (cmd.claim) begin
				route_valid_q[route_q]   <= 1'b1;
				route_channel_q[route_q] <= req_q.channel;
				route_count_q[route_q]   <= '0;
			end
			if (cmd.cnt_inc) begin
				route_count_q[route_q] <= n_cur + CNT_W'(1);
			end
			if (cmd.cnt_dec) begin
				route_count_q[route_q] <= n_cur - CNT_W'(1);
				if (n_cur == CNT_W'(1)) begin
					route_valid_q[route_q] <= 1'b0;
				end
			end
		end
	end

	// scan and shift index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.clr_idx) begin
			idx_q <= '0;
		end else if (cmd.inc_idx) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	assign idx_next = {1'b0, idx_q} + (CNT_W + 1)'(1);

	// subscriber list memory addressing
	assign base      = ADDR_W'(route_q) * SUBS_A;
	assign ram_re    = cmd.rd_scan || cmd.rd_next;
	assign ram_raddr = cmd.rd_next ? base + ADDR_W'(idx_next) : base + ADDR_W'(idx_q);
	assign ram_we    = cmd.wr_append || cmd.wr_shift;
	assign ram_waddr = cmd.wr_append ? base + ADDR_W'(n_cur) : base + ADDR_W'(idx_q);
	assign ram_wdata = cmd.wr_append ? req_q.subscriber_id : ram_rdata;

	csub_ram #(
		.WIDTH (csub_pkg::ID_W),
		.DEPTH (csub_pkg::DEPTH)
	) u_list_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			unique case (cmd.res_cnt)
				csub_pkg::CS_ZERO: res_cnt_q <= '0;
				csub_pkg::CS_CUR:  res_cnt_q <= n_cur;
				csub_pkg::CS_INC:  res_cnt_q <= n_cur + CNT_W'(1);
				csub_pkg::CS_DEC:  res_cnt_q <= n_cur - CNT_W'(1);
				default:           res_cnt_q <= '0;
			endcase
		end
	end

	// output register, drained independently of the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status      <= res_status_q;
			out_q.count_after <= 4'(res_cnt_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// status to the controller
	always_comb begin
		sts             = '0;
		sts.unsub       = (req_q.opcode == csub_pkg::OP_UNSUBSCRIBE);
		sts.handle_ok   = req_q.handle_ok;
		sts.hit         = hit_q;
		sts.free_avail  = free_q;
		sts.idx_lt_cnt  = (idx_q < n_cur);
		sts.next_lt_cnt = (idx_next < {1'b0, n_cur});
		sts.list_full   = (n_cur >= SUBS_C);
		sts.id_match    = (ram_rdata == req_q.subscriber_id);
		sts.out_busy    = out_valid_q && rsp_stall;
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_cur <= SUBS_C)
		else $error("route count above list size");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_append |-> n_cur < SUBS_C)
		else $error("append into a full list");

	a_claim_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.claim |-> !route_valid_q[route_q])
		else $error("claimed route already in use");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result not presented after load");

endmodule

### sim/csub_checker.sv
// ----------------------------------------------------------------------------
// csub_checker
// Watches the request and response channels of the subscription table, keeps
// its own copy of the routes and subscriber lists, and compares every
// response transfer against the status and count it predicts.
// ----------------------------------------------------------------------------
module csub_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  csub_pkg::req_t  req_data,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  csub_pkg::rsp_t  rsp_data,
	output int              mismatches,
	output int              outstanding
);

	// shadow copy of the route table
	bit                            route_used [csub_pkg::ROUTES];
	bit [csub_pkg::CH_W-1:0]       route_chan [csub_pkg::ROUTES];
	bit [csub_pkg::CNT_W-1:0]      route_cnt  [csub_pkg::ROUTES];
	bit [csub_pkg::ID_W-1:0]       sub_list   [csub_pkg::ROUTES][csub_pkg::SUBS_PER_ROUTE];

	csub_pkg::rsp_t  pending_rsp [$];
	csub_pkg::rsp_t  want;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	// apply one request to the shadow table and return its response
	function automatic csub_pkg::rsp_t apply_request(input csub_pkg::req_t r);
		int              hit;
		int              slot;
		int              pos;
		int              n;
		csub_pkg::rsp_t  res;
		hit  = -1;
		slot = -1;
		pos  = -1;
		n    = 0;
		res.status      = csub_pkg::ST_OK;
		res.count_after = '0;
		for (int i = 0; i < csub_pkg::ROUTES; i++) begin
			if (hit < 0 && route_used[i] && route_chan[i] == r.channel)
				hit = i;
		end
		if (r.opcode == csub_pkg::OP_SUBSCRIBE) begin
			if (!r.handle_ok) begin
				res.status = csub_pkg::ST_BAD_HANDLE;
			end else begin
				// claim the lowest free route for a new channel
				if (hit < 0) begin
					for (int i = 0; i < csub_pkg::ROUTES; i++) begin
						if (slot < 0 && !route_used[i])
							slot = i;
					end
					if (slot < 0) begin
						res.status = csub_pkg::ST_FULL;
					end else begin
						route_used[slot] = 1'b1;
						route_chan[slot] = r.channel;
						route_cnt[slot]  = '0;
						hit = slot;
					end
				end
				if (hit >= 0) begin
					n = int'(route_cnt[hit]);
					for (int i = 0; i < n; i++) begin
						if (pos < 0 && sub_list[hit][i] == r.subscriber_id)
							pos = i;
					end
					if (pos >= 0) begin
						res.count_after = n[3:0];
					end else if (n >= csub_pkg::SUBS_PER_ROUTE) begin
						res.status      = csub_pkg::ST_FULL;
						res.count_after = n[3:0];
					end else begin
						sub_list[hit][n] = r.subscriber_id;
						n = n + 1;
						route_cnt[hit]   = n[csub_pkg::CNT_W-1:0];
						res.count_after  = n[3:0];
					end
				end
			end
		end else begin
			if (hit < 0) begin
				res.status = csub_pkg::ST_NOT_FOUND;
			end else begin
				n = int'(route_cnt[hit]);
				for (int i = 0; i < n; i++) begin
					if (pos < 0 && sub_list[hit][i] == r.subscriber_id)
						pos = i;
				end
				if (pos < 0) begin
					res.status      = csub_pkg::ST_NOT_FOUND;
					res.count_after = n[3:0];
				end else begin
					// close the gap left by the removed id
					for (int k = pos; k + 1 < n; k++)
						sub_list[hit][k] = sub_list[hit][k + 1];
					n = n - 1;
					route_cnt[hit] = n[csub_pkg::CNT_W-1:0];
					if (n == 0)
						route_used[hit] = 1'b0;
					res.count_after = n[3:0];
				end
			end
		end
		return res;
	endfunction

	// predict on request transfers, compare on response transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < csub_pkg::ROUTES; i++) begin
				route_used[i] = 1'b0;
				route_chan[i] = '0;
				route_cnt[i]  = '0;
			end
			pending_rsp.delete();
			outstanding = 0;
		end else begin
			if (req_valid && !req_stall)
				pending_rsp.push_back(apply_request(req_data));
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected response transfer: status %0d count %0d",
							rsp_data.status, rsp_data.count_after);
					mismatches++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp_data.status !== want.status ||
							rsp_data.count_after !== want.count_after) begin
						if (mismatches < 10)
							$display({"response mismatch: expected status %0d count %0d,",
								" got status %0d count %0d"},
								want.status, want.count_after,
								rsp_data.status, rsp_data.count_after);
						mismatches++;
					end
				end
			end
			outstanding = pending_rsp.size();
		end
	end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives subscribe and unsubscribe requests into the channel subscription
// table: a directed pass over a full list, duplicates, refusals and route
// release, then random traffic over a small pool of channels and ids with
// random gaps, stalls, one long response hold-off and two full drains.
// ----------------------------------------------------------------------------
module tb;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	csub_pkg::req_t  req_data  = '0;
	logic            rsp_valid;
	logic            rsp_stall = 1'b0;
	csub_pkg::rsp_t  rsp_data;

	int    mismatches;
	int    outstanding;

	// traffic shaping knobs
	bit    tx_idle     = 1'b1;
	bit    rx_idle     = 1'b1;
	int    hold_cycles = 0;

	logic [csub_pkg::CH_W-1:0]  chan_pool [24];
	logic [csub_pkg::ID_W-1:0]  id_pool   [12];

	channel_subscription_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	csub_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_data    (rsp_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// response side: random stalls, plus a long hold-off on request
	initial begin : rsp_sink
		int wait_cycles;
		forever begin
			if (hold_cycles > 0) begin
				wait_cycles = hold_cycles;
				hold_cycles = 0;
			end else begin
				wait_cycles = rx_idle ? $urandom_range(0, 13) : 0;
			end
			if (wait_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	// offer one request and hold it until its transfer
	task automatic send_request(input csub_pkg::opcode_t op,
			input logic [csub_pkg::CH_W-1:0] ch,
			input logic [csub_pkg::ID_W-1:0] id, input logic ok);
		int              gap;
		csub_pkg::req_t  r;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.opcode        = op;
		r.channel       = ch;
		r.subscriber_id = id;
		r.handle_ok     = ok;
		req_data  <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// stop offering and let every predicted response come back
	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	initial begin : stimulus
		csub_pkg::opcode_t          op;
		logic [csub_pkg::CH_W-1:0]  ch;
		logic [csub_pkg::ID_W-1:0]  id;
		logic                       ok;
		int                         sub_pct;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill one list, duplicate, overflow
		send_request(csub_pkg::OP_SUBSCRIBE, 16'h0000, 32'h0000_0000, 1'b1);
		send_request(csub_pkg::OP_SUBSCRIBE, 16'h0000, 32'h0000_0000, 1'b1);
		send_request(csub_pkg::OP_SUBSCRIBE, 16'h0000, 32'hFFFF_FFFF, 1'b1);
		for (int i = 1; i <= 6; i++)
			send_request(csub_pkg::OP_SUBSCRIBE, 16'h0000, csub_pkg::ID_W'(i), 1'b1);
		send_request(csub_pkg::OP_SUBSCRIBE, 16'h0000, 32'd7, 1'b1);
		// refused handle, unknown channel, missing id
		send_request(csub_pkg::OP_SUBSCRIBE, 16'h0005, 32'd9, 1'b0);
		send_request(csub_pkg::OP_UNSUBSCRIBE, 16'h1234, 32'd1, 1'b1);
		send_request(csub_pkg::OP_UNSUBSCRIBE, 16'h0000, 32'd99, 1'b1);
		// remove from the middle, then check the shifted order
		send_request(csub_pkg::OP_UNSUBSCRIBE, 16'h0000, 32'd3, 1'b1);
		send_request(csub_pkg::OP_UNSUBSCRIBE, 16'h0000, 32'd4, 1'b0);
		send_request(csub_pkg::OP_SUBSCRIBE, 16'h0000, 32'd6, 1'b1);
		// claim a route and release it again
		send_request(csub_pkg::OP_SUBSCRIBE, 16'hFFFF, 32'hA5A5_5A5A, 1'b1);
		send_request(csub_pkg::OP_UNSUBSCRIBE, 16'hFFFF, 32'hA5A5_5A5A, 1'b1);
		send_request(csub_pkg::OP_UNSUBSCRIBE, 16'hFFFF, 32'hA5A5_5A5A, 1'b1);

		// channel pool larger than the table so it fills up
		chan_pool[0] = 16'h0000;
		chan_pool[1] = 16'hFFFF;
		for (int i = 2; i < 24; i++)
			chan_pool[i] = csub_pkg::CH_W'($urandom);

		for (int phase = 0; phase < 6; phase++) begin
			sub_pct = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 50 : 30;
			tx_idle = (phase % 2 == 0);
			rx_idle = (phase % 4 != 1);
			id_pool[0] = 32'h0000_0000;
			id_pool[1] = 32'hFFFF_FFFF;
			for (int i = 2; i < 12; i++)
				id_pool[i] = $urandom;
			// back up the response side while requests keep coming
			if (phase == 2) begin
				hold_cycles = 300;
				tx_idle     = 1'b0;
			end
			for (int k = 0; k < 300; k++) begin
				op = ($urandom_range(0, 99) < sub_pct) ? csub_pkg::OP_SUBSCRIBE
					: csub_pkg::OP_UNSUBSCRIBE;
				ch = chan_pool[$urandom_range(0, 23)];
				id = id_pool[$urandom_range(0, 11)];
				ok = ($urandom_range(0, 9) != 0);
				// occasional request outside the pools
				if ($urandom_range(0, 99) < 8) begin
					ch = csub_pkg::CH_W'($urandom);
					id = $urandom;
				end
				send_request(op, ch, id, ok);
			end
			if (phase == 3)
				wait_for_results();
		end

		wait_for_results();
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### channel_subscription_table.f
hw/rtl/csub_pkg.sv
hw/rtl/csub_ram.sv
hw/rtl/csub_ctrl.sv
hw/rtl/csub_dp.sv
hw/rtl/channel_subscription_table.sv
sim/csub_checker.sv
sim/tb.sv
